// File: src/codeword_rank_unrank_assert.svh
// Assertion macros used by the checker of this block.
// Both sample on the rising edge of clk; the first is switched off while
// rst_n is low, the second also holds during reset.
`ifndef CODEWORD_RANK_UNRANK_ASSERT_SVH
`define CODEWORD_RANK_UNRANK_ASSERT_SVH

`define CRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CRU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/cru_pkg.sv
package cru_pkg;

    // Field widths fixed by the interface.
    localparam int RANK_W     = 32;
    localparam int SIZE_W     = 33;
    localparam int ALPH_W     = 5;
    localparam int CWS_W      = 4;
    localparam int POS_W      = 3;
    localparam int LETTER_W   = 4;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_ALPHABET_SIZE = 2'd0;
    localparam cfg_idx_t CFG_CODEWORD_SIZE = 2'd1;
    localparam cfg_idx_t CFG_NO_REPEAT     = 2'd2;

    // Register values after reset.
    localparam logic [ALPH_W-1:0] RST_ALPHABET_SIZE = 5'd6;
    localparam logic [CWS_W-1:0]  RST_CODEWORD_SIZE = 4'd4;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_DERIVE,
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } cru_state_t;

endpackage

// File: src/cru_cfg_if.sv
interface cru_cfg_if;
    import cru_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/cru_rank_if.sv
interface cru_rank_if;
    import cru_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank_index;

    modport source (output valid, output rank_index, input ready);
    modport sink (input valid, input rank_index, output ready);
endinterface

// File: src/cru_result_if.sv
interface cru_result_if;
    import cru_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;
    logic [LETTER_W-1:0] letter;
    logic                out_of_range;
    logic                last;

    modport source (output valid, output position, output letter, output out_of_range,
                    output last, input ready);
    modport sink (input valid, input position, input letter, input out_of_range,
                  input last, output ready);
endinterface

// File: src/codeword_rank_unrank.sv
// Channel   Role    Payload                                    Moves
// cfg       sink    index, data                                one register write
// rank      sink    rank_index                                 one rank to unrank
// result    source  position, letter, out_of_range, last       one letter of the codeword
//
// After reset and after every register write the sizes are rebuilt by one multiply per
// cycle, or skipped for an impossible setting; no rank is taken meanwhile. An out-of-range
// rank shows its single result in the cycle after acceptance. Otherwise each position
// is found by restoring division, one quotient bit per cycle, and then held in the
// output register; a new rank is taken only after the last letter has been accepted.
// A stall on the result side simply holds the output register and the sequencer.
module codeword_rank_unrank #(
    parameter int MAX_POSITIONS = 8,
    parameter int MAX_LETTERS   = 16
) (
    input logic          clk,
    input logic          rst_n,
    cru_cfg_if.sink      cfg,
    cru_rank_if.sink     rank,
    cru_result_if.source result
);
    import cru_pkg::*;

    localparam int PIDX_W  = $clog2(MAX_POSITIONS + 1);
    localparam int FIDX_W  = $clog2(MAX_LETTERS);
    localparam int TRIAL_W = SIZE_W + LETTER_W - 1;
    localparam int PROD_W  = SIZE_W + ALPH_W;

    cru_state_t state_reg, state_next;

    // Configuration registers.
    logic [ALPH_W-1:0] alph_reg, alph_next;
    logic [CWS_W-1:0]  cws_reg, cws_next;
    logic              norep_reg, norep_next;

    // Sub-population sizes: entry j counts the codewords sharing a fixed prefix of
    // length j. Entry 0 is the whole population.
    logic [SIZE_W-1:0] subpop_reg [0:MAX_POSITIONS];
    logic              subpop_we;

    // Ordered list of letters still unused, for the no-repeat mode.
    logic [FIDX_W-1:0] free_reg [0:MAX_LETTERS-1];
    logic              free_load;
    logic              free_shift;

    // Derivation sequencer.
    logic [SIZE_W-1:0] count_reg, count_next;
    logic [PIDX_W-1:0] dj_reg, dj_next;

    // Division sequencer.
    logic [PIDX_W-1:0]   pos_reg, pos_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RANK_W-1:0]   rem_reg, rem_next;
    logic [LETTER_W-2:0] quo_reg, quo_next;

    // Output register.
    logic [POS_W-1:0]    opos_reg, opos_next;
    logic [LETTER_W-1:0] oletter_reg, oletter_next;
    logic                ooor_reg, ooor_next;
    logic                olast_reg, olast_next;

    logic                cfg_ok;
    logic [ALPH_W-1:0]   factor;
    logic [PROD_W-1:0]   prod;
    logic [SIZE_W-1:0]   divisor;
    logic [TRIAL_W-1:0]  trial;
    logic [TRIAL_W-1:0]  rem_ext;
    logic [TRIAL_W-1:0]  diff;
    logic                take;
    logic [LETTER_W-1:0] digit;
    logic [FIDX_W-1:0]   free_sel;
    logic [LETTER_W-1:0] letter_val;
    logic                in_range;

    // The configuration is impossible when a size is zero or too large, or when a
    // codeword without repeats needs more letters than the alphabet holds.
    assign cfg_ok = (alph_reg != '0) && (alph_reg <= ALPH_W'(MAX_LETTERS))
                    && (cws_reg != '0) && (cws_reg <= CWS_W'(MAX_POSITIONS))
                    && !(norep_reg && (alph_reg < ALPH_W'(cws_reg)));

    // The factor for position j is n in plain mode and n - j + 1 without repeats.
    assign factor = norep_reg ? (alph_reg - ALPH_W'(dj_reg) + ALPH_W'(1)) : alph_reg;
    assign prod   = count_reg * factor;

    // One restoring-division step: compare the remainder with the divisor shifted
    // to the weight of the current quotient bit.
    assign divisor    = subpop_reg[PIDX_W'(pos_reg + PIDX_W'(1))];
    assign trial      = TRIAL_W'(divisor) << step_reg;
    assign rem_ext    = TRIAL_W'(rem_reg);
    assign take       = rem_ext >= trial;
    assign diff       = rem_ext - trial;
    assign digit      = {quo_reg, take};
    assign free_sel   = free_reg[digit[FIDX_W-1:0]];
    assign letter_val = norep_reg ? LETTER_W'(free_sel) : digit;

    assign in_range = {1'b0, rank.rank_index} < subpop_reg[0];

    assign cfg.ready    = 1'b1;
    assign rank.ready   = (state_reg == ST_IDLE);
    assign result.valid = (state_reg == ST_OUT);

    assign result.position     = opos_reg;
    assign result.letter       = oletter_reg;
    assign result.out_of_range = ooor_reg;
    assign result.last         = olast_reg;

    always_comb
    begin
        state_next   = state_reg;
        alph_next    = alph_reg;
        cws_next     = cws_reg;
        norep_next   = norep_reg;
        count_next   = count_reg;
        dj_next      = dj_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        opos_next    = opos_reg;
        oletter_next = oletter_reg;
        ooor_next    = ooor_reg;
        olast_next   = olast_reg;
        subpop_we    = 1'b0;
        free_load    = 1'b0;
        free_shift   = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                count_next = SIZE_W'(1);
                dj_next    = PIDX_W'(cws_reg);
                state_next = cfg_ok ? ST_DERIVE : ST_IDLE;
            end
            ST_DERIVE:
            begin
                // Sizes are written from the last position back to the population.
                subpop_we = 1'b1;
                if (dj_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    count_next = prod[SIZE_W-1:0];
                    dj_next    = dj_reg - PIDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (rank.valid)
                begin
                    if (!cfg_ok || !in_range)
                    begin
                        opos_next    = '0;
                        oletter_next = '0;
                        ooor_next    = 1'b1;
                        olast_next   = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        rem_next   = rank.rank_index;
                        pos_next   = '0;
                        step_next  = STEP_W'(LETTER_W - 1);
                        quo_next   = '0;
                        free_load  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (take)
                begin
                    rem_next = diff[RANK_W-1:0];
                end
                if (step_reg == '0)
                begin
                    opos_next    = POS_W'(pos_reg);
                    oletter_next = letter_val;
                    ooor_next    = 1'b0;
                    olast_next   = (cws_reg == (CWS_W'(pos_reg) + CWS_W'(1)));
                    free_shift   = norep_reg;
                    state_next   = ST_OUT;
                end
                else
                begin
                    quo_next  = (LETTER_W - 1)'({quo_reg, take});
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + PIDX_W'(1);
                        step_next  = STEP_W'(LETTER_W - 1);
                        quo_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // A write rebuilds the sizes; user must write only while idle (not enforced).
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ALPHABET_SIZE: alph_next  = cfg.data[ALPH_W-1:0];
                CFG_CODEWORD_SIZE: cws_next   = cfg.data[CWS_W-1:0];
                CFG_NO_REPEAT:     norep_next = cfg.data[0];
                default:           ;
            endcase
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            alph_reg  <= RST_ALPHABET_SIZE;
            cws_reg   <= RST_CODEWORD_SIZE;
            norep_reg <= 1'b0;
            count_reg <= '0;
            dj_reg    <= '0;
            pos_reg   <= '0;
            step_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            alph_reg  <= alph_next;
            cws_reg   <= cws_next;
            norep_reg <= norep_next;
            count_reg <= count_next;
            dj_reg    <= dj_next;
            pos_reg   <= pos_next;
            step_reg  <= step_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opos_reg    <= opos_next;
        oletter_reg <= oletter_next;
        ooor_reg    <= ooor_next;
        olast_reg   <= olast_next;
        if (subpop_we)
        begin
            subpop_reg[dj_reg] <= count_reg;
        end
    end

    // The chosen letter leaves the list and everything behind it moves up by one.
    always_ff @(posedge clk)
    begin
        if (free_load)
        begin
            for (int k = 0; k < MAX_LETTERS; k++)
            begin
                free_reg[k] <= FIDX_W'(k);
            end
        end
        else if (free_shift)
        begin
            for (int k = 0; k < MAX_LETTERS - 1; k++)
            begin
                if (FIDX_W'(k) >= digit[FIDX_W-1:0])
                begin
                    free_reg[k] <= free_reg[k + 1];
                end
            end
        end
    end

endmodule

// File: src/cru_checker.sv
`include "codeword_rank_unrank_assert.svh"

module cru_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cru_pkg::POS_W-1:0]    out_position,
    input logic [cru_pkg::LETTER_W-1:0] out_letter,
    input logic                         out_of_range,
    input logic                         out_last
);
    import cru_pkg::*;

    // High from the acceptance of a rank until its final result is taken.
    logic busy_reg, busy_next;

    always_comb
    begin
        busy_next = busy_reg;
        if (in_valid && in_ready)
        begin
            busy_next = 1'b1;
        end
        else if (out_valid && out_ready && out_last)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    `CRU_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !out_valid, "result shown during reset")

    `CRU_ASSERT(a_oor_single, out_valid && out_of_range |-> out_last && out_position == '0 && out_letter == '0, "out-of-range result is not a lone cleared transaction")

    `CRU_ASSERT(a_one_item, in_valid && in_ready |-> !busy_reg, "rank taken before the previous codeword finished")

    `CRU_ASSERT(a_result_owned, out_valid |-> busy_reg, "result shown with no rank outstanding")

    `CRU_ASSERT(a_input_held, out_valid |-> !in_ready, "rank side ready while a result waits")

endmodule

bind codeword_rank_unrank cru_checker u_cru_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (rank.valid),
    .in_ready     (rank.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_position (result.position),
    .out_letter   (result.letter),
    .out_of_range (result.out_of_range),
    .out_last     (result.last)
);
